>>> rtl/izn_pkg.sv
// Izhikevich neuron update: shared types, codes and arithmetic helpers.
// No dependencies.
package izn_pkg;

  localparam int REG_CNT = 8;

  typedef enum logic [2:0] {
    REG_A   = 3'd0,
    REG_B   = 3'd1,
    REG_C   = 3'd2,
    REG_D   = 3'd3,
    REG_THR = 3'd4,
    REG_K1  = 3'd5,
    REG_K2  = 3'd6,
    REG_K3  = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_DV,
    ST_DIVV,
    ST_M4,
    ST_M5,
    ST_DIVU,
    ST_FIRE,
    ST_INIT,
    ST_DONE
  } state_t;

  localparam logic MODE_INIT = 1'b1;

  // Q16.16 product: floor shift by 16, clamp to 32 bits
  function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
    logic signed [47:0] s;
    s = 48'(p >>> 16);
    if (s > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    else if (s < -48'sh0000_8000_0000) return 32'sh8000_0000;
    else return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat35(input logic signed [34:0] x);
    if (x > 35'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    else if (x < -35'sh0_8000_0000) return 32'sh8000_0000;
    else return x[31:0];
  endfunction

endpackage

>>> rtl/izhikevich_neuron_update_core.sv
// Izhikevich neuron update core: state memories, one shared 32x32 multiplier
// and a sub-step sequencer. Depends on izn_pkg.
// Updates run STEPS sub-steps on the shared multiplier (states M1, M2, M3, DIVV, M4,
// M5, DIVU, FIRE) and divide by STEPS by reciprocal multiply. One word at a time:
// the next word is taken in the cycle after the result loads. Reset loads default
// coefficients and idles the sequencer; the state memories are not reset.
module izhikevich_neuron_update_core
  import izn_pkg::*;
#(
  parameter int NEURONS = 1024,
  parameter int STEPS   = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [9:0]         in_neuron_index,
  input  logic signed [31:0] in_synaptic_input,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         out_neuron_out,
  output logic               out_spike,
  output logic signed [31:0] out_voltage_out,
  output logic signed [31:0] out_recovery_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int SW = $clog2(STEPS + 1);
  // floor(n / STEPS) == (n * RECIP) >> RSH for any 32-bit n
  localparam int RSH = 32 + $clog2(STEPS);
  localparam logic [32:0] RECIP =
    33'(((64'd1 << RSH) + 64'(STEPS) - 64'd1) / 64'(STEPS));

  logic signed [31:0] cfg_r [REG_CNT];
  logic signed [31:0] vmem [NEURONS];
  logic signed [31:0] umem [NEURONS];
  logic signed [31:0] vrd_r, urd_r;

  state_t state_r, state_nxt;
  logic               mode_r;
  logic [9:0]         idx_r;
  logic signed [31:0] cur_r, v_r, u_r, t_r, p_r;
  logic               fired_r, oor_r;
  logic [SW-1:0]      step_r;
  logic               out_valid_r;
  logic [9:0]         o_idx_r;
  logic               o_spk_r;
  logic signed [31:0] o_v_r, o_u_r;

  // divide of |x| by STEPS
  logic [31:0] dn_r;
  logic        dneg_r;

  logic done_go;
  assign done_go = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_neuron_out   = o_idx_r;
  assign out_spike        = o_spk_r;
  assign out_voltage_out  = o_v_r;
  assign out_recovery_out = o_u_r;

  logic [AW-1:0] addr;
  assign addr = idx_r[AW-1:0];

  // read address follows the incoming word so data is ready in ST_READ
  logic [AW-1:0] rd_addr;
  assign rd_addr = (state_r == ST_IDLE) ? AW'(in_neuron_index) : AW'(idx_r);

  // shared multiplier operand select
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  always_comb begin
    ma = cfg_r[REG_K1];
    mb = v_r;
    unique case (state_r)
      ST_M2:   begin ma = p_r;            mb = v_r; end
      ST_M3:   begin ma = cfg_r[REG_K2];  mb = v_r; end
      ST_M4:   begin ma = cfg_r[REG_B];   mb = v_r; end
      ST_M5:   begin ma = cfg_r[REG_A];   mb = p_r; end
      ST_INIT: begin ma = cfg_r[REG_B];   mb = cfg_r[REG_C]; end
      default: begin ma = cfg_r[REG_K1];  mb = v_r; end
    endcase
  end
  assign prod = ma * mb;

  logic signed [34:0] dvsum;
  assign dvsum = 35'(t_r) + 35'(qsat(prod)) + 35'(cfg_r[REG_K3]) - 35'(u_r) + 35'(cur_r);

  logic [64:0] recip_p;
  logic [31:0] dq;
  assign recip_p = {32'd0, dn_r} * {32'd0, RECIP};
  assign dq = 32'(recip_p >> RSH);
  logic signed [31:0] qs;
  assign qs = dneg_r ? -$signed(dq) : $signed(dq);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid && in_ready) state_nxt = ST_READ;
      ST_READ: begin
        if (oor_r) state_nxt = ST_DONE;
        else if (mode_r == MODE_INIT) state_nxt = ST_INIT;
        else state_nxt = ST_M1;
      end
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_M3;
      ST_M3:   state_nxt = ST_DIVV;
      ST_DV:   state_nxt = ST_DIVV;
      ST_DIVV: state_nxt = ST_M4;
      ST_M4:   state_nxt = ST_M5;
      ST_M5:   state_nxt = ST_DIVU;
      ST_DIVU: state_nxt = ST_FIRE;
      ST_FIRE: state_nxt = (step_r == SW'(STEPS - 1)) ? ST_DONE : ST_M1;
      ST_INIT: state_nxt = ST_DONE;
      ST_DONE: if (done_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cfg_r[REG_A]   <= 32'sd1311;
      cfg_r[REG_B]   <= 32'sd13107;
      cfg_r[REG_C]   <= -32'sd4259840;
      cfg_r[REG_D]   <= 32'sd524288;
      cfg_r[REG_THR] <= 32'sd1966080;
      cfg_r[REG_K1]  <= 32'sd2621;
      cfg_r[REG_K2]  <= 32'sd327680;
      cfg_r[REG_K3]  <= 32'sd9175040;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) cfg_r[cfg_index] <= cfg_data;
      if (done_go) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    vrd_r <= vmem[rd_addr];
    urd_r <= umem[rd_addr];
    if (state_r == ST_DONE && !oor_r) begin
      vmem[addr] <= v_r;
      umem[addr] <= u_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: if (in_valid && in_ready) begin
        mode_r  <= in_mode;
        idx_r   <= in_neuron_index;
        cur_r   <= in_synaptic_input;
        oor_r   <= ({22'd0, in_neuron_index} >= 32'(NEURONS));
        fired_r <= 1'b0;
        step_r  <= '0;
      end
      ST_READ: begin
        v_r <= vrd_r;
        u_r <= urd_r;
      end
      ST_M1: p_r <= qsat(prod);
      ST_M2: t_r <= qsat(prod);
      ST_M3: begin
        dneg_r <= sat35(dvsum) < 0;
        dn_r   <= (sat35(dvsum) < 0) ? 32'(-sat35(dvsum)) : 32'(sat35(dvsum));
      end
      ST_DIVV: v_r <= sat35(35'(v_r) + 35'(qs));
      ST_DIVU: u_r <= sat35(35'(u_r) + 35'(qs));
      ST_M4: p_r <= sat35(35'(qsat(prod)) - 35'(u_r));
      ST_M5: begin
        dneg_r <= qsat(prod) < 0;
        dn_r   <= (qsat(prod) < 0) ? 32'(-33'(qsat(prod))) : 32'(qsat(prod));
      end
      ST_FIRE: begin
        step_r <= step_r + SW'(1);
        if (v_r >= cfg_r[REG_THR]) begin
          fired_r <= 1'b1;
          v_r <= cfg_r[REG_C];
          u_r <= sat35(35'(u_r) + 35'(cfg_r[REG_D]));
        end
      end
      ST_INIT: begin
        v_r <= cfg_r[REG_C];
        u_r <= qsat(prod);
        fired_r <= cfg_r[REG_C] >= cfg_r[REG_THR];
      end
      ST_DONE: if (done_go) begin
        o_idx_r <= idx_r;
        o_spk_r <= oor_r ? 1'b0 : fired_r;
        o_v_r   <= oor_r ? 32'sd0 : v_r;
        o_u_r   <= oor_r ? 32'sd0 : u_r;
      end
      default: ;
    endcase
  end

endmodule

>>> test/izhikevich_neuron_update_checker.sv
// Scoreboard for the Izhikevich neuron update core: tracks coefficient writes,
// predicts each neuron's new state per accepted word and compares results.
// Depends on izn_pkg.
module izhikevich_neuron_update_checker
  import izn_pkg::*;
#(
  parameter int NEURONS = 1024,
  parameter int STEPS   = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_mode,
  input  logic [9:0]         in_neuron_index,
  input  logic signed [31:0] in_synaptic_input,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [9:0]         out_neuron_out,
  input  logic               out_spike,
  input  logic signed [31:0] out_voltage_out,
  input  logic signed [31:0] out_recovery_out,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 pending,
  output int                 mismatches
);

  typedef struct packed {
    logic [9:0]         neuron;
    logic               spike;
    logic signed [31:0] voltage;
    logic signed [31:0] recovery;
  } neuron_state_t;

  localparam int COEFF_RESET [REG_CNT] = '{1311, 13107, -4259840, 524288, 1966080, 2621,
                                           327680, 9175040};

  int            coeff [REG_CNT];
  int            volt_mem [NEURONS];
  int            recov_mem [NEURONS];
  neuron_state_t state_q [$];

  function automatic int clamp(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return int'(x);
  endfunction

  function automatic int fx_mul(int x, int y);
    longint p;
    p = longint'(x) * longint'(y);
    return clamp(p >>> 16);
  endfunction

  function automatic neuron_state_t advance_neuron(logic mode, logic [9:0] idx, int cur);
    neuron_state_t r;
    int     a, b, c, d, thr, k1, k2, k3, v, u, dv, du, diff;
    longint sum;
    a = coeff[REG_A];   b = coeff[REG_B];    c = coeff[REG_C];  d = coeff[REG_D];
    thr = coeff[REG_THR]; k1 = coeff[REG_K1]; k2 = coeff[REG_K2]; k3 = coeff[REG_K3];
    r.neuron = idx;
    r.spike = 1'b0;
    if (idx >= NEURONS) begin
      r.voltage = '0;
      r.recovery = '0;
      return r;
    end
    if (mode == MODE_INIT) begin
      v = c;
      u = fx_mul(b, c);
      r.spike = (c >= thr);
    end else begin
      v = volt_mem[idx];
      u = recov_mem[idx];
      for (int s = 0; s < STEPS; s++) begin
        sum = longint'(fx_mul(fx_mul(k1, v), v)) + longint'(fx_mul(k2, v))
            + longint'(k3) - longint'(u) + longint'(cur);
        dv = clamp(sum);
        v = clamp(longint'(v) + longint'(dv) / STEPS);
        diff = clamp(longint'(fx_mul(b, v)) - longint'(u));
        du = fx_mul(a, diff);
        u = clamp(longint'(u) + longint'(du) / STEPS);
        if (v >= thr) begin
          r.spike = 1'b1;
          v = c;
          u = clamp(longint'(u) + longint'(d));
        end
      end
    end
    volt_mem[idx] = v;
    recov_mem[idx] = u;
    r.voltage = v;
    r.recovery = u;
    return r;
  endfunction

  always @(posedge clk) begin
    neuron_state_t want;
    if (!rst_n) begin
      for (int i = 0; i < REG_CNT; i++) coeff[i] = COEFF_RESET[i];
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) coeff[cfg_index] = cfg_data;
      if (in_valid && in_ready)
        state_q.push_back(advance_neuron(in_mode, in_neuron_index, in_synaptic_input));
      if (out_valid && out_ready) begin
        if (state_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: neuron %0d", out_neuron_out);
        end else begin
          want = state_q.pop_front();
          if (out_neuron_out !== want.neuron || out_spike !== want.spike ||
              out_voltage_out !== want.voltage || out_recovery_out !== want.recovery) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp n=%0d s=%0d v=%0d u=%0d, got n=%0d s=%0d v=%0d u=%0d",
                       want.neuron, want.spike, want.voltage, want.recovery,
                       out_neuron_out, out_spike, out_voltage_out, out_recovery_out);
          end
        end
      end
    end
    pending = state_q.size();
  end

endmodule

>>> test/tb_izhikevich_neuron_update_core.sv
// Top of the Izhikevich neuron update testbench: clock, reset, stimulus and
// verdict. Depends on izn_pkg, the core and izhikevich_neuron_update_checker.
module tb_izhikevich_neuron_update_core;
  import izn_pkg::*;

  localparam logic MODE_UPDATE = 1'b0;
  localparam int   Q_ONE = 65536;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_mode;
  logic [9:0]         in_neuron_index;
  logic signed [31:0] in_synaptic_input;
  logic               out_valid;
  logic               out_ready;
  logic [9:0]         out_neuron_out;
  logic               out_spike;
  logic signed [31:0] out_voltage_out;
  logic signed [31:0] out_recovery_out;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  int                 pending;
  int                 mismatches;

  bit                 quiet_rx;
  bit                 long_hold;
  bit                 initialized [1024];

  izhikevich_neuron_update_core dut (.*);
  izhikevich_neuron_update_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stall per word, one long hold-off on request
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      n = quiet_rx ? 0 : $urandom_range(0, 3);
      if (long_hold) begin
        n = 3000;
        long_hold = 1'b0;
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_word(logic mode, logic [9:0] idx, int cur);
    int n;
    n = $urandom_range(0, 3);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_neuron_index <= idx;
    in_synaptic_input <= cur;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (mode == MODE_INIT) initialized[idx] = 1'b1;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    repeat (3) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic load_coeffs(int vals [REG_CNT]);
    for (int r = 0; r < REG_CNT; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx_t'(r);
      cfg_data <= vals[r];
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_current(bit wild);
    if (wild) return int'($urandom);
    return int'($urandom_range(0, 25 * Q_ONE)) - 5 * Q_ONE;
  endfunction

  task automatic random_words(int count, bit wild);
    logic [9:0] idx;
    for (int i = 0; i < count; i++) begin
      idx = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 31));
      if (!initialized[idx] || $urandom_range(0, 5) == 0)
        send_word(MODE_INIT, idx, int'($urandom));
      else
        send_word(MODE_UPDATE, idx, pick_current(wild || $urandom_range(0, 4) == 0));
    end
  endtask

  initial begin
    int cfg [REG_CNT];
    int base [REG_CNT];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_UPDATE;
    in_neuron_index = '0;
    in_synaptic_input = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_A;
    cfg_data = '0;
    quiet_rx = 1'b0;
    long_hold = 1'b0;
    base = '{1311, 13107, -4259840, 524288, 1966080, 2621, 327680, 9175040};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: index extremes, current extremes, reset coefficients
    send_word(MODE_INIT, 10'd0, 32'sh7FFF_FFFF);
    send_word(MODE_INIT, 10'd1023, 32'sh8000_0000);
    send_word(MODE_INIT, 10'd512, 0);
    send_word(MODE_UPDATE, 10'd0, 0);
    send_word(MODE_UPDATE, 10'd1023, 32'sh7FFF_FFFF);
    send_word(MODE_UPDATE, 10'd512, 32'sh8000_0000);
    send_word(MODE_UPDATE, 10'd0, 10 * Q_ONE);
    send_word(MODE_UPDATE, 10'd0, 10 * Q_ONE);
    send_word(MODE_UPDATE, 10'd1023, -1);
    send_word(MODE_UPDATE, 10'd512, 32'sh7FFF_FFFF);
    drain();

    // saturation: all coefficients at the top, then the bottom, then all zero
    for (int r = 0; r < REG_CNT; r++) cfg[r] = 32'sh7FFF_FFFF;
    load_coeffs(cfg);
    send_word(MODE_INIT, 10'd0, 0);
    send_word(MODE_UPDATE, 10'd0, 32'sh7FFF_FFFF);
    send_word(MODE_UPDATE, 10'd0, 32'sh8000_0000);
    random_words(40, 1'b1);
    drain();
    for (int r = 0; r < REG_CNT; r++) cfg[r] = 32'sh8000_0000;
    load_coeffs(cfg);
    send_word(MODE_INIT, 10'd1023, 0);
    send_word(MODE_UPDATE, 10'd1023, 32'sh8000_0000);
    send_word(MODE_UPDATE, 10'd1023, 32'sh7FFF_FFFF);
    random_words(40, 1'b1);
    drain();
    cfg = '{0, 0, 0, 0, 0, 0, 0, 0};
    load_coeffs(cfg);
    random_words(30, 1'b1);
    drain();

    // realistic coefficients with jitter (fully random in one phase); long hold-off in one phase
    for (int ph = 0; ph < 7; ph++) begin
      for (int r = 0; r < REG_CNT; r++)
        cfg[r] = base[r] + int'($urandom_range(0, 2000)) - 1000;
      if (ph == 5) cfg = '{int'($urandom), int'($urandom), int'($urandom),
                           int'($urandom), int'($urandom), int'($urandom),
                           int'($urandom), int'($urandom)};
      load_coeffs(cfg);
      quiet_rx = (ph == 1);
      long_hold = (ph == 2);
      random_words(105, ph == 5);
      drain();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/izn_pkg.sv
rtl/izhikevich_neuron_update_core.sv
test/izhikevich_neuron_update_checker.sv
test/tb_izhikevich_neuron_update_core.sv
